### rtl/core/pli_pkg.sv
// Shared types and constants of the piecewise linear interpolator.
package pli_pkg;

    localparam int MAX_POINTS = 64;
    localparam int IDX_BITS   = $clog2(MAX_POINTS);
    localparam int CNT_BITS   = $clog2(MAX_POINTS + 1);
    localparam int WORD_BITS  = 32;
    localparam int DIV_BITS   = WORD_BITS + 1;
    localparam int STEP_BITS  = $clog2(DIV_BITS + 1);

    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_EVAL   = 1'b1;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_ORDER = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_EMPTY = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SRCH,
        ST_CMP,
        ST_FIRST,
        ST_F1,
        ST_F2,
        ST_ARITH
    } state_t;

    typedef struct packed {
        logic                        command;
        logic signed [WORD_BITS-1:0] point_x;
        logic signed [WORD_BITS-1:0] point_y;
        logic signed [WORD_BITS-1:0] query_x;
    } req_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] value;
        logic [1:0]                  status;
    } rsp_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] x;
        logic signed [WORD_BITS-1:0] y;
    } entry_t;

endpackage

### rtl/core/piecewise_linear_interpolator_core.sv
// Top level: piecewise linear interpolator with append and evaluate requests.
// Append and empty evaluate: result strobe in the cycle after the request, busy never rises.
// Evaluate: binary search (search and compare states per probe, 1 to 7 probes), two
// entry reads, a divider start, one multiply step, 33 divider steps and a done step,
// then the strobe; clamped answers skip the divider. One request at a time; results
// never stall. Reset (async, rst_n low) empties the table; entries need no clearing.
module piecewise_linear_interpolator_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    output logic           busy,
    input  pli_pkg::req_t  request,
    output logic           done,
    output pli_pkg::rsp_t  result
);
    import pli_pkg::*;

    state_t                    state_reg, state_next;
    logic [CNT_BITS-1:0]       count_reg, count_next;
    logic [CNT_BITS-1:0]       lo_reg, lo_next, hi_reg, hi_next;
    logic [CNT_BITS:0]         mid_sum;
    logic [CNT_BITS-1:0]       mid;
    logic signed [WORD_BITS-1:0] last_x_reg, last_y_reg, q_reg;
    logic signed [WORD_BITS-1:0] x1_reg, y1_reg, y2_reg;
    logic                      neg_reg;
    logic                      done_reg, done_next;
    rsp_t                      result_reg, result_next;

    // table memory ports
    logic                      wr_en, rd_en;
    logic [IDX_BITS-1:0]       rd_addr;
    entry_t                    wr_data, rd_data;

    // divider
    logic                      ar_start, ar_done;
    logic [DIV_BITS-1:0]       ar_a, ar_b, ar_d, ar_quo;
    logic signed [DIV_BITS-1:0] dy;
    logic signed [WORD_BITS-1:0] corr;

    logic                      accept, full, order;

    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_BITS'(MAX_POINTS));
    assign order   = (count_reg != '0) && (request.point_x < last_x_reg);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CNT_BITS:1];

    assign wr_en   = accept && (request.command == CMD_APPEND) && !full && !order;
    assign wr_data = '{x: request.point_x, y: request.point_y};

    // interpolation operands: x1 < q <= x2
    assign dy   = {rd_data.y[WORD_BITS-1], rd_data.y} - {y1_reg[WORD_BITS-1], y1_reg};
    assign ar_a = {rd_data.x[WORD_BITS-1], rd_data.x} - {q_reg[WORD_BITS-1], q_reg};
    assign ar_b = dy[DIV_BITS-1] ? DIV_BITS'(-dy) : DIV_BITS'(dy);
    assign ar_d = {rd_data.x[WORD_BITS-1], rd_data.x} - {x1_reg[WORD_BITS-1], x1_reg};
    assign corr = ar_quo[WORD_BITS-1:0];

    pli_mem u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[IDX_BITS-1:0]),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pli_arith u_arith (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ar_start),
        .a     (ar_a),
        .b     (ar_b),
        .d     (ar_d),
        .done  (ar_done),
        .quo   (ar_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
        if (wr_en)
        begin
            last_x_reg <= request.point_x;
            last_y_reg <= request.point_y;
        end
        if (accept)
        begin
            q_reg <= request.query_x;
        end
        if (state_reg == ST_F1)
        begin
            x1_reg <= rd_data.x;
            y1_reg <= rd_data.y;
        end
        if (state_reg == ST_F2)
        begin
            y2_reg  <= rd_data.y;
            neg_reg <= dy[DIV_BITS-1];
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        rd_en       = 1'b0;
        rd_addr     = mid[IDX_BITS-1:0];
        ar_start    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    result_next.value = '0;
                    if (request.command == CMD_APPEND)
                    begin
                        done_next = 1'b1;
                        if (full)
                        begin
                            result_next.status = STAT_FULL;
                        end
                        else if (order)
                        begin
                            result_next.status = STAT_ORDER;
                        end
                        else
                        begin
                            result_next.status = STAT_OK;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next = 1'b1;
                        result_next.status = STAT_EMPTY;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = count_reg;
                        state_next = ST_SRCH;
                    end
                end
            end
            ST_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    rd_en      = 1'b1;
                    state_next = ST_CMP;
                end
                else if (lo_reg == '0)
                begin
                    // at or below first breakpoint
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    state_next = ST_FIRST;
                end
                else if (lo_reg == count_reg)
                begin
                    // past the last breakpoint
                    done_next          = 1'b1;
                    result_next.value  = last_y_reg;
                    result_next.status = STAT_OK;
                    state_next         = ST_IDLE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = IDX_BITS'(lo_reg - 1'b1);
                    state_next = ST_F1;
                end
            end
            ST_CMP:
            begin
                if (rd_data.x < q_reg)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
                state_next = ST_SRCH;
            end
            ST_FIRST:
            begin
                done_next          = 1'b1;
                result_next.value  = rd_data.y;
                result_next.status = STAT_OK;
                state_next         = ST_IDLE;
            end
            ST_F1:
            begin
                rd_en      = 1'b1;
                rd_addr    = lo_reg[IDX_BITS-1:0];
                state_next = ST_F2;
            end
            ST_F2:
            begin
                ar_start   = 1'b1;
                state_next = ST_ARITH;
            end
            ST_ARITH:
            begin
                if (ar_done)
                begin
                    done_next          = 1'b1;
                    result_next.value  = neg_reg ? (y2_reg + corr) : (y2_reg - corr);
                    result_next.status = STAT_OK;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

`ifndef ASSERT_OFF
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("result strobe while busy");
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_POINTS)) else $error("table count overflow");
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.command == CMD_EVAL && count_reg != '0) |=> busy)
        else $error("evaluate did not start search");
    a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !wr_en) else $error("table write during evaluate");
`endif

endmodule

### rtl/core/pli_mem.sv
// Breakpoint table: one write port, one registered read port.
module pli_mem (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [pli_pkg::IDX_BITS-1:0]  wr_addr,
    input  pli_pkg::entry_t               wr_data,
    input  logic                          rd_en,
    input  logic [pli_pkg::IDX_BITS-1:0]  rd_addr,
    output pli_pkg::entry_t               rd_data
);
    import pli_pkg::*;

    entry_t mem [MAX_POINTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/pli_arith.sv
// Product then serial restoring division: quo = a * b / d, truncated.
module pli_arith (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pli_pkg::DIV_BITS-1:0]  a,
    input  logic [pli_pkg::DIV_BITS-1:0]  b,
    input  logic [pli_pkg::DIV_BITS-1:0]  d,
    output logic                          done,
    output logic [pli_pkg::DIV_BITS-1:0]  quo
);
    import pli_pkg::*;

    logic                    mul_reg, run_reg, done_reg;
    logic [STEP_BITS-1:0]    cnt_reg;
    logic [DIV_BITS-1:0]     a_reg, b_reg, d_reg, sh_reg;
    logic [DIV_BITS:0]       rem_reg;
    logic [2*DIV_BITS-1:0]   prod;
    logic [DIV_BITS:0]       shifted, trial;

    assign prod    = a_reg * b_reg;
    assign shifted = {rem_reg[DIV_BITS-1:0], sh_reg[DIV_BITS-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg  <= 1'b0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                mul_reg <= 1'b1;
            end
            else if (mul_reg)
            begin
                mul_reg <= 1'b0;
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_BITS'(DIV_BITS - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            b_reg <= b;
            d_reg <= d;
        end
        else if (mul_reg)
        begin
            // high half is below d since a <= d
            rem_reg <= {1'b0, prod[2*DIV_BITS-1:DIV_BITS]};
            sh_reg  <= prod[DIV_BITS-1:0];
        end
        else if (run_reg)
        begin
            if (!trial[DIV_BITS])
            begin
                rem_reg <= trial;
                sh_reg  <= {sh_reg[DIV_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                sh_reg  <= {sh_reg[DIV_BITS-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule
